// ===== src/bfra_pkg.sv =====
// ---------------------------------------------------------------------------
// bfra_pkg
// Shared constants, command and status types, and helpers for the bitmap
// free-run allocator.
// ---------------------------------------------------------------------------
package bfra_pkg;

  localparam int MAX_SLOTS = 2048;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAX_SLOTS / WORD_BITS;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int POS_W     = 12;
  localparam int SLOT_W    = 11;
  localparam int OP_W      = 2;

  localparam logic [POS_W-1:0] SLOT_COUNT_RST = POS_W'(2048);
  localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_MARK   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REWIND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the incoming slot
    logic rewind;      // zero run and search pointers
    logic clear;       // drop every mark bit
    logic mark_rd;     // read the bitmap word of the incoming slot
    logic mark_wr;     // write back that word with the slot's bit set
    logic bump;        // hand out run_next
    logic fail;        // report exhaustion
    logic scan_clr;    // start a search for a clear bit at search_pos
    logic scan_set;    // start a search for a set bit just past the hit
    logic scan_next;   // move the search to the next word
    logic take_start;  // remember the hit as the run start
    logic commit;      // install the new run and grant its first slot
    logic start_hit;   // run start is the current hit, not the stored start
    logic end_lim;     // run end is the slot limit, not the current hit
    logic emit;        // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bump_ok;
    logic pos_ge_lim;
    logic hit;
    logic hit_last;
    logic more;
    logic out_full;
  } dp_stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/bitmap_free_run_allocator_core.sv =====
// ---------------------------------------------------------------------------
// bitmap_free_run_allocator_core
// Hole-finding bump allocator over a 2048-slot mark bitmap.
// ---------------------------------------------------------------------------
// Items are handled one at a time. A rewind or clear completes on
// acceptance, and a mark reads and then writes back one 64-bit bitmap
// word. An allocate that bumps through the current free run passes
// through the S_ALLOC and S_EMIT states to the result beat. An allocate
// that needs a new run also scans the 64-slot bitmap words, first for the
// next clear bit and then for the set bit that bounds the run; the bitmap
// memory is read one word per cycle and priority encoded (at most 33
// words over both scans, since the set-bit scan may read again the word
// that held the clear bit). Clearing all marks takes effect at once, with
// no sweep after reset. The output register lets the next item be
// accepted while a result beat is still waiting to be taken.
module bitmap_free_run_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] slot, [15:11] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] slot_out, [15:11] zero
  output logic [0:0]  m_axis_tuser,   // [0] granted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data        // slot_count
);

  bfra_pkg::dp_cmd_t  cmd;
  bfra_pkg::dp_stat_t stat;
  logic [bfra_pkg::SLOT_W-1:0] slot_out;
  logic                        granted;

  bfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (bfra_pkg::op_t'(s_axis_tuser)),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfra_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_slot     (s_axis_tdata[bfra_pkg::SLOT_W-1:0]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_granted (granted),
    .out_slot    (slot_out)
  );

  assign m_axis_tdata = {{(16 - bfra_pkg::SLOT_W){1'b0}}, slot_out};
  assign m_axis_tuser = granted;

endmodule

// ===== src/bfra_ctrl.sv =====
// ---------------------------------------------------------------------------
// bfra_ctrl
// Sequencer for the allocator: decodes each item and steps the datapath
// through marks, bumps and the two-phase run search.
// ---------------------------------------------------------------------------
module bfra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfra_pkg::op_t       in_op,
  input  bfra_pkg::dp_stat_t  stat,
  output bfra_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK_WR,
    S_ALLOC,
    S_SCAN_FREE,
    S_SCAN_USED,
    S_EMIT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_op)
            bfra_pkg::OP_MARK: begin
              cmd.mark_rd = 1'b1;
              state_next  = S_MARK_WR;
            end
            bfra_pkg::OP_ALLOC: begin
              state_next = S_ALLOC;
            end
            bfra_pkg::OP_REWIND: begin
              cmd.rewind = 1'b1;
            end
            bfra_pkg::OP_CLEAR: begin
              cmd.rewind = 1'b1;
              cmd.clear  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_ALLOC: begin
        if (stat.bump_ok) begin
          cmd.bump   = 1'b1;
          state_next = S_EMIT;
        end else if (stat.pos_ge_lim) begin
          cmd.fail   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN_FREE;
        end
      end
      S_SCAN_FREE: begin
        if (stat.hit) begin
          cmd.take_start = 1'b1;
          if (stat.hit_last) begin
            // The free bit is the last usable slot, so the run ends at the limit.
            cmd.commit    = 1'b1;
            cmd.start_hit = 1'b1;
            cmd.end_lim   = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.scan_set = 1'b1;
            state_next   = S_SCAN_USED;
          end
        end else if (stat.more) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.fail   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_SCAN_USED: begin
        if (stat.hit) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT;
        end else if (stat.more) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.commit  = 1'b1;
          cmd.end_lim = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/bfra_dpath.sv =====
// ---------------------------------------------------------------------------
// bfra_dpath
// Mark bitmap memory, run and search pointers, word scanner with priority
// encoding, slot count register and output register.
// ---------------------------------------------------------------------------
module bfra_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [bfra_pkg::SLOT_W-1:0]            in_slot,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bfra_pkg::POS_W-1:0]             cfg_data,
  input  bfra_pkg::dp_cmd_t                      cmd,
  output bfra_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_granted,
  output logic [bfra_pkg::SLOT_W-1:0]            out_slot
);

  localparam int WORD_BITS = bfra_pkg::WORD_BITS;
  localparam int WORD_AW   = bfra_pkg::WORD_AW;
  localparam int BIT_W     = bfra_pkg::BIT_W;
  localparam int POS_W     = bfra_pkg::POS_W;
  localparam int SLOT_W    = bfra_pkg::SLOT_W;
  localparam int MAP_WORDS = bfra_pkg::MAP_WORDS;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] mem_q;
  logic                 mem_vld_q;

  logic [SLOT_W-1:0]  slot_q;
  logic [POS_W-1:0]   run_next;
  logic [POS_W-1:0]   run_limit;
  logic [POS_W-1:0]   search_pos;
  logic [POS_W-1:0]   slot_count;
  logic [WORD_AW-1:0] scan_word;
  logic [POS_W-1:0]   scan_from;
  logic               want;
  logic [POS_W-1:0]   start_q;
  logic               res_granted;
  logic [SLOT_W-1:0]  res_slot;

  logic [POS_W-1:0]     lim;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;
  logic [POS_W-1:0]     base;
  logic [POS_W-1:0]     lim_rel;
  logic [POS_W-1:0]     hit_pos;
  logic [POS_W-1:0]     set_from;
  logic [POS_W-1:0]     run_start;
  logic [POS_W-1:0]     run_end;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;

  assign cfg_ready = 1'b1;

  assign lim = (slot_count > POS_W'(bfra_pkg::MAX_SLOTS)) ?
               POS_W'(bfra_pkg::MAX_SLOTS) : slot_count;

  // A word never written since reset or the last clear reads as all zeros.
  assign rd_word = mem_vld_q ? mem_q : '0;

  // Scanner: keep only bits in [scan_from, lim) of the current word.
  assign base    = POS_W'({scan_word, {BIT_W{1'b0}}});
  assign lim_rel = lim - base;
  assign lo_mask = (scan_word == scan_from[WORD_AW+BIT_W-1:BIT_W]) ?
                   ({WORD_BITS{1'b1}} << scan_from[BIT_W-1:0]) : {WORD_BITS{1'b1}};
  assign hi_mask = (lim_rel >= POS_W'(WORD_BITS)) ? {WORD_BITS{1'b1}} :
                   ((WORD_BITS'(1) << lim_rel[BIT_W-1:0]) - WORD_BITS'(1));
  assign cand     = (want ? rd_word : ~rd_word) & lo_mask & hi_mask;
  assign hit_pos  = POS_W'({scan_word, bfra_pkg::lowest_set(cand)});
  assign set_from = hit_pos + POS_W'(1);

  assign stat.bump_ok    = (run_next < run_limit) && (run_next < lim);
  assign stat.pos_ge_lim = (search_pos >= lim);
  assign stat.hit        = |cand;
  assign stat.hit_last   = (set_from >= lim);
  assign stat.more       = ((base + POS_W'(WORD_BITS)) < lim);
  assign stat.out_full   = out_valid && !out_ready;

  assign run_start = cmd.start_hit ? hit_pos : start_q;
  assign run_end   = cmd.end_lim ? lim : hit_pos;

  always_comb begin
    rd_en   = cmd.mark_rd | cmd.scan_clr | cmd.scan_set | cmd.scan_next;
    rd_addr = scan_word;
    if (cmd.mark_rd) begin
      rd_addr = in_slot[WORD_AW+BIT_W-1:BIT_W];
    end else if (cmd.scan_clr) begin
      rd_addr = search_pos[WORD_AW+BIT_W-1:BIT_W];
    end else if (cmd.scan_set) begin
      rd_addr = set_from[WORD_AW+BIT_W-1:BIT_W];
    end else if (cmd.scan_next) begin
      rd_addr = scan_word + WORD_AW'(1);
    end
  end

  // Bitmap memory: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (cmd.mark_wr) begin
      mem[slot_q[WORD_AW+BIT_W-1:BIT_W]] <=
        rd_word | (WORD_BITS'(1) << slot_q[BIT_W-1:0]);
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      mem_vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clear) begin
      vld <= '0;
    end else if (cmd.mark_wr) begin
      vld[slot_q[WORD_AW+BIT_W-1:BIT_W]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= bfra_pkg::SLOT_COUNT_RST;
    end else if (cfg_valid) begin
      slot_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_next   <= '0;
      run_limit  <= '0;
      search_pos <= '0;
    end else if (cmd.rewind) begin
      run_next   <= '0;
      run_limit  <= '0;
      search_pos <= '0;
    end else if (cmd.bump) begin
      run_next <= run_next + POS_W'(1);
    end else if (cmd.commit) begin
      run_next   <= run_start + POS_W'(1);
      run_limit  <= run_end;
      search_pos <= (run_end == bfra_pkg::POS_MAX) ? run_end : run_end + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_q <= in_slot;
    end
    if (cmd.scan_clr) begin
      scan_word <= rd_addr;
      scan_from <= search_pos;
      want      <= 1'b0;
    end else if (cmd.scan_set) begin
      scan_word <= rd_addr;
      scan_from <= set_from;
      want      <= 1'b1;
    end else if (cmd.scan_next) begin
      scan_word <= rd_addr;
    end
    if (cmd.take_start) begin
      start_q <= hit_pos;
    end
    if (cmd.bump) begin
      res_granted <= 1'b1;
      res_slot    <= run_next[SLOT_W-1:0];
    end else if (cmd.fail) begin
      res_granted <= 1'b0;
      res_slot    <= '0;
    end else if (cmd.commit) begin
      res_granted <= 1'b1;
      res_slot    <= run_start[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_granted <= res_granted;
      out_slot    <= res_slot;
    end
  end

  a_commit_run_order: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> run_next <= run_limit)
    else $error("new run starts past its end");

  a_bump_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.bump |-> (run_next < lim) && (run_next < run_limit))
    else $error("bump outside the current run");

  a_start_below_lim: assert property (@(posedge clk) disable iff (rst)
    cmd.take_start |-> hit_pos < lim)
    else $error("run start at or past the slot limit");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwrites an undelivered beat");

  a_search_word_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_next |-> stat.more && !stat.hit)
    else $error("search stepped past the slot limit");

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_free_run_allocator_core. A queue of commands
// feeds a stream driver, and a shadow copy of the mark bitmap and run pointers
// predicts every allocate result. The monitor compares each result beat with
// the oldest prediction. The slot count changes between phases while the
// block is idle, and both stream sides stall at random.
// ---------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat before giving up
  localparam int SETTLE      = 120;   // longest search plus margin
  localparam int HOLD_AT     = 300;   // commands sent before the long sink hold
  localparam int HOLD_CYCLES = 250;
  localparam int SWEEP_SLOTS = 1060;
  localparam int PHASE_CMDS  = 8;

  typedef struct {
    bfra_pkg::op_t                 op;
    logic [bfra_pkg::SLOT_W-1:0]   slot;
  } alloc_cmd_t;

  typedef struct {
    logic                          granted;
    logic [bfra_pkg::SLOT_W-1:0]   slot;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = bfra_pkg::OP_MARK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;

  alloc_cmd_t queued_cmds[$];
  grant_t     pending_grants[$];

  // Shadow of the allocator state.
  logic [bfra_pkg::MAX_SLOTS-1:0] shadow_marks;
  logic [bfra_pkg::POS_W-1:0]     shadow_next;
  logic [bfra_pkg::POS_W-1:0]     shadow_limit;
  logic [bfra_pkg::POS_W-1:0]     shadow_search;
  logic [bfra_pkg::POS_W-1:0]     shadow_count;

  int mismatches = 0;
  int cmds_sent  = 0;
  bit calm       = 1'b0;

  int phase_counts [8] = '{64, 1, 130, 4095, 0, 2047, 700, 2048};

  bitmap_free_run_allocator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // First index in [from, lim) whose mark equals want; lim when none.
  function automatic int find_mark(input int from, input int lim, input logic want);
    for (int i = from; i < lim; i++) begin
      if (shadow_marks[i] == want) begin
        return i;
      end
    end
    return lim;
  endfunction

  function automatic grant_t next_grant();
    grant_t g;
    int     lim;
    int     start;
    int     stop;
    g.granted = 1'b0;
    g.slot    = '0;
    lim = (int'(shadow_count) > bfra_pkg::MAX_SLOTS) ? bfra_pkg::MAX_SLOTS :
          int'(shadow_count);
    if (int'(shadow_next) < int'(shadow_limit) && int'(shadow_next) < lim) begin
      g.granted   = 1'b1;
      g.slot      = shadow_next[bfra_pkg::SLOT_W-1:0];
      shadow_next = shadow_next + bfra_pkg::POS_W'(1);
    end else begin
      start = find_mark(int'(shadow_search), lim, 1'b0);
      // On exhaustion the run and search pointers are left untouched.
      if (start < lim) begin
        stop          = find_mark(start + 1, lim, 1'b1);
        shadow_next   = bfra_pkg::POS_W'(start + 1);
        shadow_limit  = bfra_pkg::POS_W'(stop);
        shadow_search = (stop + 1 > int'(bfra_pkg::POS_MAX)) ? bfra_pkg::POS_MAX :
                        bfra_pkg::POS_W'(stop + 1);
        g.granted     = 1'b1;
        g.slot        = bfra_pkg::SLOT_W'(start);
      end
    end
    return g;
  endfunction

  function automatic void track_cmd(input bfra_pkg::op_t op,
                                    input logic [bfra_pkg::SLOT_W-1:0] slot);
    case (op)
      bfra_pkg::OP_MARK: begin
        shadow_marks[slot] = 1'b1;
      end
      bfra_pkg::OP_ALLOC: begin
        pending_grants.push_back(next_grant());
      end
      bfra_pkg::OP_REWIND, bfra_pkg::OP_CLEAR: begin
        if (op == bfra_pkg::OP_CLEAR) begin
          shadow_marks = '0;
        end
        shadow_next   = '0;
        shadow_limit  = '0;
        shadow_search = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Command driver: presents queued commands, with random gaps between them.
  always @(posedge clk) begin : cmd_driver
    alloc_cmd_t c;
    logic       vld_n;
    int         gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap = 0;
    end else begin
      vld_n = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        track_cmd(bfra_pkg::op_t'(s_axis_tuser), s_axis_tdata[bfra_pkg::SLOT_W-1:0]);
        cmds_sent++;
        vld_n = 1'b0;
      end
      if (!vld_n) begin
        if (gap == 0 && queued_cmds.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
          gap = $urandom_range(1, 9);
        end
        if (gap > 0) begin
          gap--;
        end else if (queued_cmds.size() > 0) begin
          c = queued_cmds.pop_front();
          s_axis_tdata <= {5'b0, c.slot};
          s_axis_tuser <= c.op;
          vld_n = 1'b1;
        end
      end
      s_axis_tvalid <= vld_n;
    end
  end

  // Result sink: random short stalls, plus one long hold that backs up the block.
  always @(posedge clk) begin : result_sink
    logic rdy_n;
    int   stall;
    int   hold_left;
    bit   hold_done;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall     = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rdy_n = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy_n = 1'b0;
      end else if (!hold_done && cmds_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy_n     = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rdy_n = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        rdy_n = 1'b0;
      end
      m_axis_tready <= rdy_n;
    end
  end

  always @(posedge clk) begin : result_monitor
    grant_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result beat: granted %0b, slot_out %0d",
               m_axis_tuser[0], m_axis_tdata[bfra_pkg::SLOT_W-1:0]);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tuser[0] !== want.granted) begin
          $error("granted: expected %0b, actual %0b", want.granted, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata[bfra_pkg::SLOT_W-1:0] !== want.slot) begin
          $error("slot_out: expected %0d, actual %0d", want.slot,
                 m_axis_tdata[bfra_pkg::SLOT_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_cmd(input bfra_pkg::op_t op, input int slot);
    alloc_cmd_t c;
    c.op   = op;
    c.slot = bfra_pkg::SLOT_W'(slot);
    queued_cmds.push_back(c);
  endtask

  task automatic wait_for_drain();
    while (queued_cmds.size() != 0 || s_axis_tvalid || pending_grants.size() != 0) begin
      @(posedge clk);
    end
    // Marks leave no result, so give the last one time to land.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slot_count(input int count);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 12'(count);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid    <= 1'b0;
    shadow_count = 12'(count);
  endtask

  initial begin : stimulus
    int lim;
    int r;
    shadow_marks  = '0;
    shadow_next   = '0;
    shadow_limit  = '0;
    shadow_search = '0;
    shadow_count  = bfra_pkg::SLOT_COUNT_RST;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A fresh bitmap is one run over the whole slab; a mark inside the
    // current run does not shorten it.
    push_cmd(bfra_pkg::OP_ALLOC, 0);
    push_cmd(bfra_pkg::OP_ALLOC, 2047);
    push_cmd(bfra_pkg::OP_MARK, 3);
    push_cmd(bfra_pkg::OP_ALLOC, 0);
    push_cmd(bfra_pkg::OP_ALLOC, 0);
    push_cmd(bfra_pkg::OP_MARK, 2047);
    push_cmd(bfra_pkg::OP_MARK, 0);
    push_cmd(bfra_pkg::OP_MARK, 'h555);
    push_cmd(bfra_pkg::OP_MARK, 'h2aa);
    push_cmd(bfra_pkg::OP_REWIND, 0);
    repeat (3) push_cmd(bfra_pkg::OP_ALLOC, 0);
    push_cmd(bfra_pkg::OP_CLEAR, 0);
    push_cmd(bfra_pkg::OP_ALLOC, 0);

    // No usable slot at all, then a single one.
    write_slot_count(0);
    push_cmd(bfra_pkg::OP_ALLOC, 0);
    write_slot_count(1);
    push_cmd(bfra_pkg::OP_REWIND, 0);
    repeat (2) push_cmd(bfra_pkg::OP_ALLOC, 0);

    // Every usable slot marked: exhaustion with the pointers kept.
    write_slot_count(4);
    for (int i = 0; i < 4; i++) push_cmd(bfra_pkg::OP_MARK, i);
    push_cmd(bfra_pkg::OP_REWIND, 0);
    push_cmd(bfra_pkg::OP_ALLOC, 0);

    // Oversized count acts as the full slab; then a run left beyond a
    // lowered count must fall back to a search.
    write_slot_count(4095);
    repeat (2) push_cmd(bfra_pkg::OP_ALLOC, 0);
    write_slot_count(10);
    repeat (6) push_cmd(bfra_pkg::OP_ALLOC, 0);
    write_slot_count(2048);

    // Sweep a little past the middle of the slab with random marks ahead of
    // the allocations.
    push_cmd(bfra_pkg::OP_CLEAR, 0);
    for (int s = 0; s < SWEEP_SLOTS; s++) begin
      if ($urandom_range(0, 99) < 45) begin
        push_cmd(bfra_pkg::OP_MARK, s);
      end else begin
        push_cmd(bfra_pkg::OP_ALLOC, $urandom_range(0, 2047));
      end
    end

    foreach (phase_counts[p]) begin
      write_slot_count(phase_counts[p]);
      if (p == $size(phase_counts) - 1) begin
        calm = 1'b1;
      end
      lim = (phase_counts[p] > bfra_pkg::MAX_SLOTS) ? bfra_pkg::MAX_SLOTS : phase_counts[p];
      for (int k = 0; k < PHASE_CMDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          if (lim > 0 && $urandom_range(0, 3) != 0) begin
            push_cmd(bfra_pkg::OP_MARK, $urandom_range(0, lim - 1));
          end else begin
            push_cmd(bfra_pkg::OP_MARK, $urandom_range(0, 2047));
          end
        end else if (r < 85) begin
          push_cmd(bfra_pkg::OP_ALLOC, $urandom_range(0, 2047));
        end else if (r < 95) begin
          push_cmd(bfra_pkg::OP_REWIND, $urandom_range(0, 2047));
        end else begin
          push_cmd(bfra_pkg::OP_CLEAR, $urandom_range(0, 2047));
        end
      end
    end

    wait_for_drain();
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
